// ===== sv/tti_pkg.sv =====
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, constants and helpers of the trilinear table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int MAX_X      = 16;
    localparam int MAX_Y      = 16;
    localparam int MAX_Z      = 16;
    localparam int VAR_STRIDE = 32;

    localparam int VAL_W    = 48;
    localparam int FRAC_W   = 32;
    localparam int INV_W    = 47;
    localparam int PTS_W    = 5;
    localparam int NV_W     = 6;
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 17;
    localparam int CFG_IX_W = 3;
    localparam int CFG_W    = INV_W;
    localparam int SPLIT_W  = VAL_W / 2;
    localparam int IDX_W    = VAL_W - FRAC_W + 1;

    localparam int X_W     = $clog2(MAX_X);
    localparam int Y_W     = $clog2(MAX_Y);
    localparam int Z_W     = $clog2(MAX_Z);
    localparam int V_W     = $clog2(VAR_STRIDE);
    localparam int TAB_AW  = V_W + X_W + Y_W + Z_W;
    localparam int TAB_DEPTH = VAR_STRIDE * MAX_X * MAX_Y * MAX_Z;
    localparam int CORNERS = 8;
    localparam int K_W     = $clog2(CORNERS);

    localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(16);
    localparam logic [NV_W-1:0]  NV_RESET  = NV_W'(32);
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(64'd4294967296);

    // corner k lowers the axis index where the bit is set
    localparam logic [CORNERS-1:0] CORNER_LX = 8'b1011_0010;
    localparam logic [CORNERS-1:0] CORNER_LY = 8'b1101_0100;
    localparam logic [CORNERS-1:0] CORNER_LZ = 8'b1110_1000;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [OP_W-1:0] {
        OP_WR_X   = 3'd0,
        OP_WR_Y   = 3'd1,
        OP_WR_Z   = 3'd2,
        OP_WR_TAB = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_X_PTS = 3'd0,
        CFG_Y_PTS = 3'd1,
        CFG_Z_PTS = 3'd2,
        CFG_NVARS = 3'd3,
        CFG_X_INV = 3'd4,
        CFG_Y_INV = 3'd5,
        CFG_Z_INV = 3'd6
    } cfg_ix_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] write_address;
        val_t              write_value;
        val_t              query_x;
        val_t              query_y;
        val_t              query_z;
    } req_t;

    typedef struct packed {
        val_t           interp_value;
        logic [V_W-1:0] var_index;
        logic           last;
    } res_t;

    typedef enum logic [4:0] {
        SRC_XI, SRC_YI, SRC_ZI, SRC_DXY, SRC_DXZ, SRC_DYZ, SRC_DXYZ,
        SRC_OX, SRC_OY, SRC_OZ,
        SRC_E1, SRC_E2, SRC_E3, SRC_E4, SRC_E5, SRC_E6, SRC_E7,
        SRC_DX, SRC_DY, SRC_DZ, SRC_T
    } src_t;

    typedef enum logic [3:0] {
        DST_T, DST_ACC, DST_DXY, DST_DXZ, DST_DYZ, DST_DXYZ,
        DST_SX, DST_SY, DST_SZ
    } dst_t;

    typedef struct packed {
        src_t a;
        src_t b;
        dst_t dst;
    } mstep_t;

    localparam int NSTEP     = 26;
    localparam int STEP_W    = $clog2(NSTEP);
    localparam int PRE_LAST  = 6;
    localparam int VAR_FIRST = 7;
    localparam int VAR_LAST  = NSTEP - 1;

    // product program: per-query terms first, then the per-variable terms
    localparam mstep_t PROG [NSTEP] = '{
        '{SRC_XI,   SRC_YI, DST_DXY},
        '{SRC_XI,   SRC_ZI, DST_DXZ},
        '{SRC_YI,   SRC_ZI, DST_DYZ},
        '{SRC_DXY,  SRC_ZI, DST_DXYZ},
        '{SRC_OX,   SRC_XI, DST_SX},
        '{SRC_OY,   SRC_YI, DST_SY},
        '{SRC_OZ,   SRC_ZI, DST_SZ},
        '{SRC_XI,   SRC_E1, DST_T},
        '{SRC_T,    SRC_DX, DST_ACC},
        '{SRC_YI,   SRC_E2, DST_T},
        '{SRC_T,    SRC_DY, DST_ACC},
        '{SRC_ZI,   SRC_E3, DST_T},
        '{SRC_T,    SRC_DZ, DST_ACC},
        '{SRC_DXY,  SRC_E4, DST_T},
        '{SRC_T,    SRC_DX, DST_T},
        '{SRC_T,    SRC_DY, DST_ACC},
        '{SRC_DXZ,  SRC_E5, DST_T},
        '{SRC_T,    SRC_DX, DST_T},
        '{SRC_T,    SRC_DZ, DST_ACC},
        '{SRC_DYZ,  SRC_E6, DST_T},
        '{SRC_T,    SRC_DY, DST_T},
        '{SRC_T,    SRC_DZ, DST_ACC},
        '{SRC_DXYZ, SRC_E7, DST_T},
        '{SRC_T,    SRC_DX, DST_T},
        '{SRC_T,    SRC_DY, DST_T},
        '{SRC_T,    SRC_DZ, DST_ACC}
    };

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_CELL, ST_GRID_RD, ST_GRID_LD,
        ST_RD, ST_RD_WAIT, ST_DIFF, ST_VAR, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_LO, PH_HI, PH_WB
    } phase_t;

    typedef struct packed {
        logic           accept;
        logic           load_query;
        logic           mul_lo;
        logic           mul_hi;
        logic           mul_wb;
        src_t           a_sel;
        src_t           b_sel;
        dst_t           dst;
        logic           cell_load;
        logic           grid_rd;
        logic           grid_ld;
        logic           rd_en;
        logic [K_W-1:0] rd_k;
        logic [V_W-1:0] var_idx;
        logic           diff;
        logic           emit;
        logic           last;
    } cmd_t;

    typedef struct packed {
        logic [NV_W-1:0] nv;
    } stat_t;

    function automatic logic [PTS_W-1:0] clamp_pts(input logic [PTS_W-1:0] v,
                                                   input logic [PTS_W-1:0] mx);
        logic [PTS_W-1:0] r;
        if (v < PTS_W'(2))
            r = PTS_W'(2);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

    // 1 + integer part of the scaled offset, limited to 1..n-1
    function automatic logic [PTS_W-1:0] cell_idx(input val_t s,
                                                  input logic [PTS_W-1:0] n);
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] lim;
        logic [PTS_W-1:0] r;
        idx = IDX_W'(s[VAL_W-2:FRAC_W]) + IDX_W'(1);
        lim = IDX_W'(n) - IDX_W'(1);
        if (s[VAL_W-1])
            r = PTS_W'(1);
        else if (idx > lim)
            r = lim[PTS_W-1:0];
        else
            r = idx[PTS_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/tti_mul.sv =====
// ----------------------------------------------------------------------------
// tti_mul
// Shared Q16.32 multiplier: two half-width partial products, then sum/shift.
// ----------------------------------------------------------------------------
module tti_mul (
    input  logic          clk,
    input  logic          lo_en,
    input  logic          hi_en,
    input  tti_pkg::val_t a,
    input  tti_pkg::val_t b,
    output tti_pkg::val_t q
);

    localparam int LO_PW = tti_pkg::VAL_W + tti_pkg::SPLIT_W + 1;
    localparam int HI_PW = tti_pkg::VAL_W + tti_pkg::VAL_W - tti_pkg::SPLIT_W;
    localparam int SUM_W = 2 * tti_pkg::VAL_W;

    logic signed [LO_PW-1:0] plo_reg;
    logic signed [HI_PW-1:0] phi_reg;
    logic signed [SUM_W-1:0] sum;

    always_ff @(posedge clk)
    begin
        if (lo_en)
            plo_reg <= a * $signed({1'b0, b[tti_pkg::SPLIT_W-1:0]});
        if (hi_en)
            phi_reg <= a * $signed(b[tti_pkg::VAL_W-1:tti_pkg::SPLIT_W]);
    end

    assign sum = SUM_W'(plo_reg) + (SUM_W'(phi_reg) <<< tti_pkg::SPLIT_W);
    assign q   = sum[tti_pkg::FRAC_W+tti_pkg::VAL_W-1:tti_pkg::FRAC_W];

endmodule

// ===== sv/tti_dp.sv =====
// ----------------------------------------------------------------------------
// tti_dp
// Datapath: config registers, grid and table memories, corner capture,
// product operands and accumulation, result register.
// ----------------------------------------------------------------------------
module tti_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tti_pkg::req_t                   request,
    input  logic                            cfg_write,
    input  logic [tti_pkg::CFG_IX_W-1:0]    cfg_index,
    input  logic [tti_pkg::CFG_W-1:0]       cfg_data,
    input  tti_pkg::cmd_t                   cmd,
    output tti_pkg::stat_t                  stat,
    output logic                            result_valid,
    output tti_pkg::res_t                   result
);

    logic [tti_pkg::PTS_W-1:0] x_pts_reg, y_pts_reg, z_pts_reg;
    logic [tti_pkg::NV_W-1:0]  nv_reg;
    logic [tti_pkg::INV_W-1:0] x_inv_reg, y_inv_reg, z_inv_reg;

    tti_pkg::val_t tab_mem [tti_pkg::TAB_DEPTH];
    tti_pkg::val_t x_mem [tti_pkg::MAX_X];
    tti_pkg::val_t y_mem [tti_pkg::MAX_Y];
    tti_pkg::val_t z_mem [tti_pkg::MAX_Z];

    tti_pkg::val_t gx0_reg, gy0_reg, gz0_reg;
    tti_pkg::val_t px_reg, py_reg, pz_reg;
    tti_pkg::val_t ox_reg, oy_reg, oz_reg;
    tti_pkg::val_t gqx_reg, gqy_reg, gqz_reg;
    tti_pkg::val_t dx_reg, dy_reg, dz_reg;
    tti_pkg::val_t dxy_reg, dxz_reg, dyz_reg, dxyz_reg;
    tti_pkg::val_t sx_reg, sy_reg, sz_reg;
    tti_pkg::val_t t_reg, acc_reg;
    tti_pkg::val_t e_reg [1:tti_pkg::CORNERS-1];
    tti_pkg::val_t f_reg [tti_pkg::CORNERS];
    tti_pkg::val_t rd_q_reg;
    logic [tti_pkg::K_W-1:0] k_d_reg;
    logic                    rd_v_reg;

    logic [tti_pkg::X_W-1:0] ix_reg;
    logic [tti_pkg::Y_W-1:0] iy_reg;
    logic [tti_pkg::Z_W-1:0] iz_reg;

    logic [tti_pkg::PTS_W-1:0] cx, cy, cz;
    logic [tti_pkg::X_W-1:0]   ax;
    logic [tti_pkg::Y_W-1:0]   ay;
    logic [tti_pkg::Z_W-1:0]   az;
    logic [tti_pkg::TAB_AW-1:0] rd_addr;
    logic [tti_pkg::NV_W-1:0]  nv_c;
    tti_pkg::val_t op_a, op_b, mq;
    tti_pkg::val_t xi, yi, zi;
    logic wr_x, wr_y, wr_z, wr_tab;

    assign xi = tti_pkg::val_t'({1'b0, x_inv_reg});
    assign yi = tti_pkg::val_t'({1'b0, y_inv_reg});
    assign zi = tti_pkg::val_t'({1'b0, z_inv_reg});

    assign wr_x   = cmd.accept && (request.op == tti_pkg::OP_WR_X)
                    && (32'(request.write_address) < tti_pkg::MAX_X);
    assign wr_y   = cmd.accept && (request.op == tti_pkg::OP_WR_Y)
                    && (32'(request.write_address) < tti_pkg::MAX_Y);
    assign wr_z   = cmd.accept && (request.op == tti_pkg::OP_WR_Z)
                    && (32'(request.write_address) < tti_pkg::MAX_Z);
    assign wr_tab = cmd.accept && (request.op == tti_pkg::OP_WR_TAB)
                    && (32'(request.write_address) < tti_pkg::TAB_DEPTH);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pts_reg <= tti_pkg::PTS_RESET;
            y_pts_reg <= tti_pkg::PTS_RESET;
            z_pts_reg <= tti_pkg::PTS_RESET;
            nv_reg    <= tti_pkg::NV_RESET;
            x_inv_reg <= tti_pkg::INV_RESET;
            y_inv_reg <= tti_pkg::INV_RESET;
            z_inv_reg <= tti_pkg::INV_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tti_pkg::CFG_X_PTS: x_pts_reg <= cfg_data[tti_pkg::PTS_W-1:0];
                tti_pkg::CFG_Y_PTS: y_pts_reg <= cfg_data[tti_pkg::PTS_W-1:0];
                tti_pkg::CFG_Z_PTS: z_pts_reg <= cfg_data[tti_pkg::PTS_W-1:0];
                tti_pkg::CFG_NVARS: nv_reg    <= cfg_data[tti_pkg::NV_W-1:0];
                tti_pkg::CFG_X_INV: x_inv_reg <= cfg_data;
                tti_pkg::CFG_Y_INV: y_inv_reg <= cfg_data;
                tti_pkg::CFG_Z_INV: z_inv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (nv_reg == '0)
            nv_c = tti_pkg::NV_W'(1);
        else if (nv_reg > tti_pkg::NV_W'(tti_pkg::VAR_STRIDE))
            nv_c = tti_pkg::NV_W'(tti_pkg::VAR_STRIDE);
        else
            nv_c = nv_reg;
    end
    assign stat.nv = nv_c;

    // grid memories
    always_ff @(posedge clk)
    begin
        if (wr_x)
            x_mem[request.write_address[tti_pkg::X_W-1:0]] <= request.write_value;
        if (wr_y)
            y_mem[request.write_address[tti_pkg::Y_W-1:0]] <= request.write_value;
        if (wr_z)
            z_mem[request.write_address[tti_pkg::Z_W-1:0]] <= request.write_value;
        if (cmd.grid_rd)
        begin
            gqx_reg <= x_mem[ix_reg];
            gqy_reg <= y_mem[iy_reg];
            gqz_reg <= z_mem[iz_reg];
        end
    end

    // origin copies
    always_ff @(posedge clk)
    begin
        if (wr_x && (request.write_address == '0))
            gx0_reg <= request.write_value;
        if (wr_y && (request.write_address == '0))
            gy0_reg <= request.write_value;
        if (wr_z && (request.write_address == '0))
            gz0_reg <= request.write_value;
    end

    // table memory
    assign ax = ix_reg - tti_pkg::X_W'(tti_pkg::CORNER_LX[cmd.rd_k]);
    assign ay = iy_reg - tti_pkg::Y_W'(tti_pkg::CORNER_LY[cmd.rd_k]);
    assign az = iz_reg - tti_pkg::Z_W'(tti_pkg::CORNER_LZ[cmd.rd_k]);
    assign rd_addr = {az, ay, ax, cmd.var_idx};

    always_ff @(posedge clk)
    begin
        if (wr_tab)
            tab_mem[request.write_address[tti_pkg::TAB_AW-1:0]] <= request.write_value;
        if (cmd.rd_en)
            rd_q_reg <= tab_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= cmd.rd_en;
            result_valid <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        k_d_reg <= cmd.rd_k;
        if (rd_v_reg)
            f_reg[k_d_reg] <= rd_q_reg;
    end

    // query point and cell selection
    assign cx = tti_pkg::cell_idx(sx_reg, tti_pkg::clamp_pts(x_pts_reg,
                                  tti_pkg::PTS_W'(tti_pkg::MAX_X)));
    assign cy = tti_pkg::cell_idx(sy_reg, tti_pkg::clamp_pts(y_pts_reg,
                                  tti_pkg::PTS_W'(tti_pkg::MAX_Y)));
    assign cz = tti_pkg::cell_idx(sz_reg, tti_pkg::clamp_pts(z_pts_reg,
                                  tti_pkg::PTS_W'(tti_pkg::MAX_Z)));

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            px_reg <= request.query_x;
            py_reg <= request.query_y;
            pz_reg <= request.query_z;
            ox_reg <= request.query_x - gx0_reg - tti_pkg::val_t'(1);
            oy_reg <= request.query_y - gy0_reg - tti_pkg::val_t'(1);
            oz_reg <= request.query_z - gz0_reg - tti_pkg::val_t'(1);
        end
        if (cmd.cell_load)
        begin
            ix_reg <= cx[tti_pkg::X_W-1:0];
            iy_reg <= cy[tti_pkg::Y_W-1:0];
            iz_reg <= cz[tti_pkg::Z_W-1:0];
        end
        if (cmd.grid_ld)
        begin
            dx_reg <= gqx_reg - px_reg;
            dy_reg <= gqy_reg - py_reg;
            dz_reg <= gqz_reg - pz_reg;
        end
    end

    // product operands
    function automatic tti_pkg::val_t pick(input tti_pkg::src_t s);
        tti_pkg::val_t v;
        case (s)
            tti_pkg::SRC_XI:   v = xi;
            tti_pkg::SRC_YI:   v = yi;
            tti_pkg::SRC_ZI:   v = zi;
            tti_pkg::SRC_DXY:  v = dxy_reg;
            tti_pkg::SRC_DXZ:  v = dxz_reg;
            tti_pkg::SRC_DYZ:  v = dyz_reg;
            tti_pkg::SRC_DXYZ: v = dxyz_reg;
            tti_pkg::SRC_OX:   v = ox_reg;
            tti_pkg::SRC_OY:   v = oy_reg;
            tti_pkg::SRC_OZ:   v = oz_reg;
            tti_pkg::SRC_E1:   v = e_reg[1];
            tti_pkg::SRC_E2:   v = e_reg[2];
            tti_pkg::SRC_E3:   v = e_reg[3];
            tti_pkg::SRC_E4:   v = e_reg[4];
            tti_pkg::SRC_E5:   v = e_reg[5];
            tti_pkg::SRC_E6:   v = e_reg[6];
            tti_pkg::SRC_E7:   v = e_reg[7];
            tti_pkg::SRC_DX:   v = dx_reg;
            tti_pkg::SRC_DY:   v = dy_reg;
            tti_pkg::SRC_DZ:   v = dz_reg;
            tti_pkg::SRC_T:    v = t_reg;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        op_a = pick(cmd.a_sel);
        op_b = pick(cmd.b_sel);
    end

    tti_mul u_mul (
        .clk   (clk),
        .lo_en (cmd.mul_lo),
        .hi_en (cmd.mul_hi),
        .a     (op_a),
        .b     (op_b),
        .q     (mq)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            acc_reg  <= f_reg[0];
            e_reg[1] <= f_reg[1] - f_reg[0];
            e_reg[2] <= f_reg[2] - f_reg[0];
            e_reg[3] <= f_reg[3] - f_reg[0];
            e_reg[4] <= f_reg[4] - f_reg[1] - f_reg[2] + f_reg[0];
            e_reg[5] <= f_reg[5] - f_reg[1] - f_reg[3] + f_reg[0];
            e_reg[6] <= f_reg[6] - f_reg[2] - f_reg[3] + f_reg[0];
            e_reg[7] <= f_reg[7] - f_reg[0] + f_reg[1] + f_reg[2] + f_reg[3]
                        - f_reg[4] - f_reg[5] - f_reg[6];
        end
        else if (cmd.mul_wb)
        begin
            case (cmd.dst)
                tti_pkg::DST_T:    t_reg    <= mq;
                tti_pkg::DST_ACC:  acc_reg  <= acc_reg + mq;
                tti_pkg::DST_DXY:  dxy_reg  <= mq;
                tti_pkg::DST_DXZ:  dxz_reg  <= mq;
                tti_pkg::DST_DYZ:  dyz_reg  <= mq;
                tti_pkg::DST_DXYZ: dxyz_reg <= mq;
                tti_pkg::DST_SX:   sx_reg   <= mq;
                tti_pkg::DST_SY:   sy_reg   <= mq;
                tti_pkg::DST_SZ:   sz_reg   <= mq;
                default: ;
            endcase
        end
        if (cmd.emit)
        begin
            result.interp_value <= acc_reg;
            result.var_index    <= cmd.var_idx;
            result.last         <= cmd.last;
        end
    end

endmodule

// ===== sv/tti_ctrl.sv =====
// ----------------------------------------------------------------------------
// tti_ctrl
// Query sequencer: product program, cell lookup, corner reads, emission.
// ----------------------------------------------------------------------------
module tti_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tti_pkg::OP_W-1:0]    op,
    input  tti_pkg::stat_t              stat,
    output tti_pkg::cmd_t               cmd,
    output logic                        busy
);

    tti_pkg::state_t state_reg, state_next;
    tti_pkg::phase_t ph_reg, ph_next;
    logic [tti_pkg::STEP_W-1:0] step_reg, step_next;
    logic [tti_pkg::K_W-1:0]    k_reg, k_next;
    logic [tti_pkg::V_W-1:0]    var_reg, var_next;
    logic                       last_var;
    logic                       mul_state;

    assign last_var  = ({1'b0, var_reg} == (stat.nv - tti_pkg::NV_W'(1)));
    assign mul_state = (state_reg == tti_pkg::ST_PRE) || (state_reg == tti_pkg::ST_VAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tti_pkg::ST_IDLE;
            ph_reg    <= tti_pkg::PH_LO;
            step_reg  <= '0;
            k_reg     <= '0;
            var_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            var_reg   <= var_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        var_next   = var_reg;
        case (state_reg)
            tti_pkg::ST_IDLE:
            begin
                if (start && (op == tti_pkg::OP_QUERY))
                begin
                    state_next = tti_pkg::ST_PRE;
                    ph_next    = tti_pkg::PH_LO;
                    step_next  = '0;
                    var_next   = '0;
                end
            end
            tti_pkg::ST_PRE, tti_pkg::ST_VAR:
            begin
                case (ph_reg)
                    tti_pkg::PH_LO: ph_next = tti_pkg::PH_HI;
                    tti_pkg::PH_HI: ph_next = tti_pkg::PH_WB;
                    default:
                    begin
                        ph_next = tti_pkg::PH_LO;
                        if (step_reg == tti_pkg::STEP_W'(tti_pkg::PRE_LAST)
                            && state_reg == tti_pkg::ST_PRE)
                            state_next = tti_pkg::ST_CELL;
                        else if (step_reg == tti_pkg::STEP_W'(tti_pkg::VAR_LAST))
                            state_next = tti_pkg::ST_EMIT;
                        else
                            step_next = step_reg + tti_pkg::STEP_W'(1);
                    end
                endcase
            end
            tti_pkg::ST_CELL:    state_next = tti_pkg::ST_GRID_RD;
            tti_pkg::ST_GRID_RD: state_next = tti_pkg::ST_GRID_LD;
            tti_pkg::ST_GRID_LD:
            begin
                state_next = tti_pkg::ST_RD;
                k_next     = '0;
            end
            tti_pkg::ST_RD:
            begin
                k_next = k_reg + tti_pkg::K_W'(1);
                if (k_reg == tti_pkg::K_W'(tti_pkg::CORNERS - 1))
                    state_next = tti_pkg::ST_RD_WAIT;
            end
            tti_pkg::ST_RD_WAIT: state_next = tti_pkg::ST_DIFF;
            tti_pkg::ST_DIFF:
            begin
                state_next = tti_pkg::ST_VAR;
                ph_next    = tti_pkg::PH_LO;
                step_next  = tti_pkg::STEP_W'(tti_pkg::VAR_FIRST);
            end
            tti_pkg::ST_EMIT:
            begin
                if (last_var)
                    state_next = tti_pkg::ST_IDLE;
                else
                begin
                    state_next = tti_pkg::ST_RD;
                    k_next     = '0;
                    var_next   = var_reg + tti_pkg::V_W'(1);
                end
            end
            default: state_next = tti_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == tti_pkg::ST_IDLE) && start;
        cmd.load_query = cmd.accept && (op == tti_pkg::OP_QUERY);
        cmd.a_sel      = tti_pkg::PROG[step_reg].a;
        cmd.b_sel      = tti_pkg::PROG[step_reg].b;
        cmd.dst        = tti_pkg::PROG[step_reg].dst;
        cmd.mul_lo     = mul_state && (ph_reg == tti_pkg::PH_LO);
        cmd.mul_hi     = mul_state && (ph_reg == tti_pkg::PH_HI);
        cmd.mul_wb     = mul_state && (ph_reg == tti_pkg::PH_WB);
        cmd.cell_load  = (state_reg == tti_pkg::ST_CELL);
        cmd.grid_rd    = (state_reg == tti_pkg::ST_GRID_RD);
        cmd.grid_ld    = (state_reg == tti_pkg::ST_GRID_LD);
        cmd.rd_en      = (state_reg == tti_pkg::ST_RD);
        cmd.rd_k       = k_reg;
        cmd.var_idx    = var_reg;
        cmd.diff       = (state_reg == tti_pkg::ST_DIFF);
        cmd.emit       = (state_reg == tti_pkg::ST_EMIT);
        cmd.last       = last_var;
    end

    assign busy = (state_reg != tti_pkg::ST_IDLE);

endmodule

// ===== sv/trilinear_table_interp.sv =====
// ----------------------------------------------------------------------------
// trilinear_table_interp
// Trilinear interpolation over an equidistant 3-D table of up to 32 variables.
// ----------------------------------------------------------------------------
// Write items (grid coordinates, table words) never raise busy. A query holds
// busy through seven per-query products first, then, for each of the clamped
// count of variables, eight corner reads through the single table read port
// and nineteen Q16.32 products on one shared 48x25 multiplier, each product in
// a low, a high and a write-back phase. Results leave one per variable, each
// on a single-cycle result_valid strobe; the receiver cannot stall them, so it
// must take every transfer as it comes. Configuration must be written by the
// user only while busy is low; the block itself does not enforce it.
module trilinear_table_interp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  tti_pkg::req_t                   request,
    output logic                            busy,
    input  logic                            cfg_write,
    input  logic [tti_pkg::CFG_IX_W-1:0]    cfg_index,
    input  logic [tti_pkg::CFG_W-1:0]       cfg_data,
    output logic                            result_valid,
    output tti_pkg::res_t                   result
);

    tti_pkg::cmd_t  cmd;
    tti_pkg::stat_t stat;

    tti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tti_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sv/tti_checker.sv =====
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks on query/result sequencing of the interpolator.
// ----------------------------------------------------------------------------
module tti_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input tti_pkg::req_t request,
    input logic          busy,
    input logic          result_valid,
    input tti_pkg::res_t result
);

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.op == tti_pkg::OP_QUERY) |=> busy)
        else $error("accepted query did not raise busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result transfer without a query in progress");

    a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back result transfers");

    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> busy)
        else $error("query ended before its last result");

endmodule

bind trilinear_table_interp tti_checker u_tti_checker (.*);
